/* hw/rtl/character_cell_pixel_generator_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the character cell pixel generator checks.
// ----------------------------------------------------------------------------
`ifndef CHARACTER_CELL_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define CHARACTER_CELL_PIXEL_GENERATOR_TOP_ASSERT_SVH

// check outside reset
`define CCPG_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ccpg assertion failed");

// check that also covers reset
`define CCPG_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ccpg reset assertion failed");

`endif

/* hw/rtl/ccpg_pkg.sv */
// ----------------------------------------------------------------------------
// ccpg_pkg
// Types, constants and address helpers of the character cell pixel generator.
// ----------------------------------------------------------------------------
package ccpg_pkg;

  localparam int PAGE_BYTES_DEF = 8192;
  localparam int PAGES_DEF      = 2;
  localparam int MAX_LINES_DEF  = 320;

  localparam logic [12:0] ATTR_BASE    = 13'h1800;
  localparam logic [9:0]  ACTIVE_LINES = 10'd192;
  localparam logic [5:0]  ACTIVE_COLS  = 6'd32;
  localparam logic [7:0]  FIRST_LINE_RESET = 8'd64;
  localparam logic [4:0]  FLASH_MASK   = 5'h1F;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic {
    REG_FIRST_LINE = 1'b0,
    REG_PARTIAL    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [8:0] line;
    logic [5:0] col;
    logic [7:0] bits;
    logic [3:0] fg;
    logic [3:0] bg;
    logic [2:0] first;
    logic [2:0] last;
  } cell_t;

  // interleaved bitmap address of a cell
  function automatic logic [12:0] bitmap_addr(input logic [7:0] row, input logic [4:0] col);
    bitmap_addr = {row[7:6], row[2:0], row[5:3], col};
  endfunction

  function automatic logic [12:0] attr_addr(input logic [7:0] row, input logic [4:0] col);
    attr_addr = ATTR_BASE + 13'({row[7:3], col});
  endfunction

endpackage

/* hw/rtl/ccpg_ram.sv */
// ----------------------------------------------------------------------------
// ccpg_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ccpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/ccpg_pixel_out.sv */
// ----------------------------------------------------------------------------
// ccpg_pixel_out
// Pixel emitter: walks one resolved cell, one pixel word per cycle unless pixel_stall holds it.
// ----------------------------------------------------------------------------
module ccpg_pixel_out
  import ccpg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  cell_t      cell_word,
  output logic       free,
  output logic       pixel_valid,
  input  logic       pixel_stall,
  output logic [8:0] pixel_line,
  output logic [8:0] pixel_x,
  output logic [3:0] color_index,
  output logic       last
);

  cell_t      cur;
  logic [2:0] pos;
  logic       busy;

  assign last        = (pos == cur.last);
  assign free        = !busy || (!pixel_stall && last);
  assign pixel_valid = busy;
  assign pixel_line  = cur.line;
  assign pixel_x     = {cur.col, pos};
  assign color_index = cur.bits[3'd7 - pos] ? cur.fg : cur.bg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (busy && !pixel_stall && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= cell_word;
      pos <= cell_word.first;
    end else if (busy && !pixel_stall && !last) begin
      pos <= pos + 3'd1;
    end
  end

endmodule

/* hw/rtl/character_cell_pixel_generator_top.sv */
// ----------------------------------------------------------------------------
// character_cell_pixel_generator_top
// Character cell pixel generator with two pages of video memory.
// ----------------------------------------------------------------------------
// Input words (item_valid / item_stall) carry one operation: draw a cell,
// write one video memory byte, or advance the flash counter. Output words
// (pixel_valid / pixel_stall) carry one pixel each: line, x position,
// 4-bit color index and a last flag on the final pixel of a cell.
// Configuration is written through cfg_write / cfg_index / cfg_data, and the
// user must write it while the block is idle; the block does not enforce it.
// A draw word is taken into a fetch stage that reads bitmap and attribute
// from two RAM copies; the fetch stage then loads the pixel emitter, whose
// registered outputs carry the first pixel word once the emitter is free.
// The pixel emitter sends one pixel per cycle while pixel_stall is low, and
// the next cell follows without a gap; the emitter is the rate limit.
// Writes and ticks emit nothing.
// Reset clears the pipeline, saved bytes and flash counter and loads the
// configuration defaults; video memory is not cleared. When the receiver
// stalls, the current pixel holds, the fetch stage fills and item_stall rises.
// ----------------------------------------------------------------------------
module character_cell_pixel_generator_top
  import ccpg_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int PAGES      = PAGES_DEF,
  parameter int MAX_LINES  = MAX_LINES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  op,
  input  logic [8:0]  scan_line,
  input  logic [5:0]  column,
  input  logic [2:0]  first_pixel,
  input  logic [2:0]  last_pixel,
  input  logic        fetch,
  input  logic [2:0]  border_color,
  input  logic        screen_page,
  input  logic [12:0] mem_address,
  input  logic [7:0]  mem_data,
  output logic        pixel_valid,
  input  logic        pixel_stall,
  output logic [8:0]  pixel_line,
  output logic [8:0]  pixel_x,
  output logic [3:0]  color_index,
  output logic        last
);

  localparam int DEPTH  = PAGES * PAGE_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [9:0] LINE_LIMIT = 10'(MAX_LINES);

  logic [7:0] first_active_line;
  logic       partial_span_mode;
  logic [7:0] saved_bitmap;
  logic [7:0] saved_attribute;
  logic [4:0] flash_counter;

  logic       accept;
  logic       is_draw;
  logic       is_active;
  logic [9:0] line_ext;
  logic [9:0] fal_ext;
  logic [7:0] row;
  logic [2:0] span_first;
  logic [2:0] span_last;
  logic       page_sel;
  logic [ADDR_W-1:0] page_base;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] bm_raddr;
  logic [ADDR_W-1:0] at_raddr;
  logic [7:0] bm_rdata;
  logic [7:0] at_rdata;

  logic       s1_valid;
  logic [8:0] s1_line;
  logic [5:0] s1_col;
  logic [2:0] s1_first;
  logic [2:0] s1_last;
  logic       s1_has_pix;
  logic       s1_active;
  logic       s1_fetch;
  logic [2:0] s1_border;
  logic       s1_flash;
  logic       s1_adv;

  logic [7:0] cur_bits;
  logic [7:0] cur_attr;
  logic [3:0] ink;
  logic [3:0] paper;
  logic       swap;
  cell_t      cell_word;
  logic       em_free;
  logic       em_load;

  assign item_stall = s1_valid && !s1_adv;
  assign accept     = item_valid && !item_stall;

  assign line_ext  = {1'b0, scan_line};
  assign fal_ext   = {2'b00, first_active_line};
  assign is_draw   = (op == OP_DRAW) && (line_ext < LINE_LIMIT);
  assign is_active = (line_ext >= fal_ext) && (line_ext < fal_ext + ACTIVE_LINES) &&
                     (column < ACTIVE_COLS);
  assign row       = 8'(line_ext - fal_ext);
  assign span_first = partial_span_mode ? first_pixel : 3'd0;
  assign span_last  = partial_span_mode ? last_pixel  : 3'd7;

  assign page_sel  = (PAGES > 1) ? screen_page : 1'b0;
  assign page_base = page_sel ? ADDR_W'(PAGE_BYTES) : '0;
  assign waddr     = page_base + ADDR_W'(mem_address);
  assign bm_raddr  = page_base + ADDR_W'(bitmap_addr(row, column[4:0]));
  assign at_raddr  = page_base + ADDR_W'(attr_addr(row, column[4:0]));

  ccpg_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_bitmap_ram (
    .clk  (clk),
    .we   (accept && (op == OP_WRITE)),
    .waddr(waddr),
    .wdata(mem_data),
    .re   (accept),
    .raddr(bm_raddr),
    .rdata(bm_rdata)
  );

  ccpg_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_attr_ram (
    .clk  (clk),
    .we   (accept && (op == OP_WRITE)),
    .waddr(waddr),
    .wdata(mem_data),
    .re   (accept),
    .raddr(at_raddr),
    .rdata(at_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_active_line <= FIRST_LINE_RESET;
      partial_span_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FIRST_LINE: first_active_line <= cfg_data;
        REG_PARTIAL:    partial_span_mode <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_counter <= '0;
    end else if (accept && (op == OP_TICK)) begin
      flash_counter <= (flash_counter + 5'd1) & FLASH_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && is_draw) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_line    <= scan_line;
      s1_col     <= column;
      s1_first   <= span_first;
      s1_last    <= span_last;
      s1_has_pix <= (span_first <= span_last);
      s1_active  <= is_active;
      s1_fetch   <= fetch;
      s1_border  <= border_color;
      s1_flash   <= flash_counter[4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saved_bitmap    <= '0;
      saved_attribute <= '0;
    end else if (s1_adv && s1_active && s1_fetch) begin
      saved_bitmap    <= bm_rdata;
      saved_attribute <= at_rdata;
    end
  end

  assign s1_adv  = s1_valid && (!s1_has_pix || em_free);
  assign em_load = s1_adv && s1_has_pix;

  always_comb begin
    cur_bits = s1_fetch ? bm_rdata : saved_bitmap;
    cur_attr = s1_fetch ? at_rdata : saved_attribute;
    ink      = {cur_attr[6], cur_attr[2:0]};
    paper    = {cur_attr[6], cur_attr[5:3]};
    swap     = cur_attr[7] && s1_flash;
    cell_word.line  = s1_line;
    cell_word.col   = s1_col;
    cell_word.first = s1_first;
    cell_word.last  = s1_last;
    if (s1_active) begin
      cell_word.bits = cur_bits;
      cell_word.fg   = swap ? paper : ink;
      cell_word.bg   = swap ? ink : paper;
    end else begin
      cell_word.bits = '0;
      cell_word.fg   = {1'b0, s1_border};
      cell_word.bg   = {1'b0, s1_border};
    end
  end

  ccpg_pixel_out u_pixel_out (
    .clk        (clk),
    .rst        (rst),
    .load       (em_load),
    .cell_word  (cell_word),
    .free       (em_free),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel_line (pixel_line),
    .pixel_x    (pixel_x),
    .color_index(color_index),
    .last       (last)
  );

endmodule

/* hw/rtl/ccpg_checker.sv */
// ----------------------------------------------------------------------------
// ccpg_checker
// Port-level checks of the character cell pixel generator, bound to the top.
// ----------------------------------------------------------------------------
`include "character_cell_pixel_generator_top_assert.svh"

module ccpg_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_write,
  input logic        cfg_index,
  input logic [7:0]  cfg_data,
  input logic        item_valid,
  input logic        item_stall,
  input logic [1:0]  op,
  input logic [8:0]  scan_line,
  input logic [5:0]  column,
  input logic [2:0]  first_pixel,
  input logic [2:0]  last_pixel,
  input logic        fetch,
  input logic [2:0]  border_color,
  input logic        screen_page,
  input logic [12:0] mem_address,
  input logic [7:0]  mem_data,
  input logic        pixel_valid,
  input logic        pixel_stall,
  input logic [8:0]  pixel_line,
  input logic [8:0]  pixel_x,
  input logic [3:0]  color_index,
  input logic        last
);

  // hold a stalled pixel word
  `CCPG_ASSERT(a_stall_hold, pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_x) && $stable(color_index) && $stable(last))

  // advance to the next pixel of the same cell without a gap
  `CCPG_ASSERT(a_cell_walk, pixel_valid && !pixel_stall && !last |=> pixel_valid && (pixel_x == $past(pixel_x) + 9'd1) && $stable(pixel_line))

  // border cells right of the active columns never carry bright
  `CCPG_ASSERT(a_border_dim, pixel_valid && pixel_x[8] |-> !color_index[3])

  // drop output after reset
  `CCPG_ASSERT_RST(a_reset_idle, rst |=> !pixel_valid)

endmodule

bind character_cell_pixel_generator_top ccpg_checker u_ccpg_checker (.*);
